>>> hdl/gbs_pkg.sv
// Shared types and constants of the greedy box suppression block.
package gbs_pkg;

	// fixed field widths of the channel words
	localparam int FIELD_W = 16;
	localparam int THR_W   = 16;
	localparam int SLOT_W  = 8;

	// overlap threshold after reset, about 0.45 in Q0.16
	localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_AREA   = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} gbs_state_t;

	// status of the compare pipeline toward the controller
	typedef struct packed {
		logic busy;
		logic hit;
	} cmp_stat_t;

endpackage

>>> hdl/gbs_if.sv
// Valid/ready channel interfaces for box words and result words.
interface gbs_box_if import gbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      start_set;
	logic signed [FIELD_W-1:0] x_min;
	logic signed [FIELD_W-1:0] y_min;
	logic signed [FIELD_W-1:0] x_max;
	logic signed [FIELD_W-1:0] y_max;

	modport source (output valid, start_set, x_min, y_min, x_max, y_max, input ready);
	modport sink   (input valid, start_set, x_min, y_min, x_max, y_max, output ready);
endinterface

interface gbs_res_if import gbs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              keep;
	logic [SLOT_W-1:0] kept_slot;
	logic              status;

	modport source (output valid, keep, kept_slot, status, input ready);
	modport sink   (input valid, keep, kept_slot, status, output ready);
endinterface

>>> hdl/gbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/gbs_cmp.sv
// Overlap compare pipeline: one kept entry per cycle against the current box.
module gbs_cmp import gbs_pkg::*; #(
	parameter int CW = 16,
	localparam int AREA_W = 2*CW + 2,
	localparam int UNI_W  = AREA_W + 2,
	localparam int P_W    = UNI_W + THR_W + 1,
	localparam int ENT_W  = 4*CW + AREA_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     issue,
	input  logic signed [CW-1:0]     nx0,
	input  logic signed [CW-1:0]     ny0,
	input  logic signed [CW-1:0]     nx1,
	input  logic signed [CW-1:0]     ny1,
	input  logic signed [AREA_W-1:0] area,
	input  logic [THR_W-1:0]         thr,
	input  logic [ENT_W-1:0]         entry,
	output cmp_stat_t                stat
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic hit_q;

	// stage 1: kept entry fields straight off the RAM
	logic signed [CW-1:0]     kx0, ky0, kx1, ky1;
	logic signed [AREA_W-1:0] ka;
	logic signed [CW-1:0]     lo_x, hi_x, lo_y, hi_y;
	logic signed [CW:0]       iw_c, ih_c;
	logic                     disj_c;

	always_comb begin
		kx0  = signed'(entry[ENT_W-1 -: CW]);
		ky0  = signed'(entry[ENT_W-1-CW -: CW]);
		kx1  = signed'(entry[ENT_W-1-2*CW -: CW]);
		ky1  = signed'(entry[ENT_W-1-3*CW -: CW]);
		ka   = signed'(entry[AREA_W-1:0]);
		hi_x = (nx1 < kx1) ? nx1 : kx1;
		lo_x = (nx0 > kx0) ? nx0 : kx0;
		hi_y = (ny1 < ky1) ? ny1 : ky1;
		lo_y = (ny0 > ky0) ? ny0 : ky0;
		iw_c = (CW+1)'(hi_x) - (CW+1)'(lo_x);
		ih_c = (CW+1)'(hi_y) - (CW+1)'(lo_y);
		disj_c = (nx0 > kx1) || (nx1 < kx0) || (ny0 > ky1) || (ny1 < ky0);
	end

	logic signed [CW:0]       iw_s2, ih_s2;
	logic                     disj_s2;
	logic signed [AREA_W-1:0] ka_s2, ka_s3, inter_s3, inter_s4, inter_s5;
	logic signed [UNI_W-1:0]  uni_s4;
	logic signed [P_W-1:0]    prod_s5;

	logic signed [AREA_W-1:0] inter_c;
	logic signed [UNI_W-1:0]  uni_c;
	logic signed [P_W-1:0]    thr_ext, prod_c, lhs_c;

	always_comb begin
		inter_c = disj_s2 ? '0 : AREA_W'(iw_s2) * AREA_W'(ih_s2);
		uni_c   = UNI_W'(area) + UNI_W'(ka_s3) - UNI_W'(inter_s3);
		thr_ext = P_W'(signed'({1'b0, thr}));
		prod_c  = thr_ext * P_W'(uni_s4);
		lhs_c   = P_W'(inter_s5) <<< THR_W;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// payload stages: widths, intersection, union, threshold product
	always_ff @(posedge clk) begin
		iw_s2    <= iw_c;
		ih_s2    <= ih_c;
		disj_s2  <= disj_c;
		ka_s2    <= ka;
		inter_s3 <= inter_c;
		ka_s3    <= ka_s2;
		uni_s4   <= uni_c;
		inter_s4 <= inter_s3;
		prod_s5  <= prod_c;
		inter_s5 <= inter_s4;
	end

	// sticky suppression flag: inter * 2^16 > thr * union
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (clear) begin
			hit_q <= 1'b0;
		end else if (v_s5 && (lhs_c > prod_s5)) begin
			hit_q <= 1'b1;
		end
	end

	assign stat.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign stat.hit  = hit_q;

endmodule

>>> hdl/greedy_box_suppression.sv
// Top level: greedy class-agnostic box suppression with a kept-box RAM.
//
//  channel  | dir | word                                   | handshake
//  ---------+-----+----------------------------------------+-----------------
//  in_box   | in  | start_set, x_min, y_min, x_max, y_max  | valid/ready
//  out_res  | out | keep, kept_slot, status                | valid/ready
//  cfg      | in  | iou_threshold (cfg_wdata)              | cfg_we, no wait
//
// One box at a time: each box is compared with every kept box, read through the
// single read port of the kept-box RAM, which feeds one stored box per cycle
// into the five-stage compare pipeline. The RAM holds no reset; kept_count is
// cleared by reset and by start_set. A result held by a stalled out_res delays
// the next box only after that box has finished its scan.
module greedy_box_suppression import gbs_pkg::*; #(
	parameter int MAX_KEPT   = 256,
	parameter int COORD_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	gbs_box_if.sink          in_box,
	gbs_res_if.source        out_res
);

	localparam int CW     = (COORD_BITS > FIELD_W) ? FIELD_W : COORD_BITS;
	localparam int AW     = $clog2(MAX_KEPT);
	localparam int CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int AREA_W = 2*CW + 2;
	localparam int ENT_W  = 4*CW + AREA_W;

	gbs_state_t state_q;
	logic [THR_W-1:0]         thr_q;
	logic [CNT_W-1:0]         cnt_q, idx_q;
	logic signed [CW-1:0]     nx0_q, ny0_q, nx1_q, ny1_q;
	logic signed [CW:0]       dx_q, dy_q;
	logic signed [AREA_W-1:0] area_q;
	logic                     out_vld_q, keep_q, status_q;
	logic [SLOT_W-1:0]        slot_q;

	cmp_stat_t cmp_stat;

	// input fields narrowed to the coordinate width
	logic signed [CW-1:0] sx0, sy0, sx1, sy1;
	assign sx0 = signed'(in_box.x_min[CW-1:0]);
	assign sy0 = signed'(in_box.y_min[CW-1:0]);
	assign sx1 = signed'(in_box.x_max[CW-1:0]);
	assign sy1 = signed'(in_box.y_max[CW-1:0]);

	logic in_go, issue, full, fin_go, ram_we;
	logic [CNT_W+SLOT_W-1:0] cnt_wide;

	assign in_box.ready = (state_q == ST_IDLE);
	assign in_go   = in_box.valid && in_box.ready;
	assign issue   = (state_q == ST_SCAN) && (idx_q < cnt_q);
	assign full    = (cnt_q == CNT_W'(MAX_KEPT));
	assign fin_go  = (state_q == ST_FINISH) && (!out_vld_q || out_res.ready);
	assign ram_we  = fin_go && !cmp_stat.hit && !full;
	assign cnt_wide = {{SLOT_W{1'b0}}, cnt_q};

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_go) begin
						if (in_box.start_set) begin
							cnt_q <= '0;
						end
						state_q <= ST_AREA;
					end
				end
				ST_AREA: begin
					idx_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!cmp_stat.busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						if (ram_we) begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// box payload and its area
	always_ff @(posedge clk) begin
		if (in_go) begin
			nx0_q <= sx0;
			ny0_q <= sy0;
			nx1_q <= sx1;
			ny1_q <= sy1;
			dx_q  <= (CW+1)'(sx1) - (CW+1)'(sx0);
			dy_q  <= (CW+1)'(sy1) - (CW+1)'(sy0);
		end
		if (state_q == ST_AREA) begin
			area_q <= AREA_W'(dx_q) * AREA_W'(dy_q);
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin_go) begin
			out_vld_q <= 1'b1;
		end else if (out_res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			keep_q   <= ram_we;
			status_q <= !cmp_stat.hit && full;
			slot_q   <= ram_we ? cnt_wide[SLOT_W-1:0] : '0;
		end
	end

	assign out_res.valid     = out_vld_q;
	assign out_res.keep      = keep_q;
	assign out_res.kept_slot = slot_q;
	assign out_res.status    = status_q;

	// kept-box store: four coordinates and the area per entry
	logic [ENT_W-1:0] rd_entry;

	gbs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_KEPT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({nx0_q, ny0_q, nx1_q, ny1_q, area_q}),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_entry)
	);

	gbs_cmp #(
		.CW (CW)
	) u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (state_q == ST_AREA),
		.issue  (issue),
		.nx0    (nx0_q),
		.ny0    (ny0_q),
		.nx1    (nx1_q),
		.ny1    (ny1_q),
		.area   (area_q),
		.thr    (thr_q),
		.entry  (rd_entry),
		.stat   (cmp_stat)
	);

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_KEPT))
		else $error("kept count beyond store depth");

	a_we_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_FINISH) && !full && !cmp_stat.hit)
		else $error("store write outside a keep decision");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_box.ready |-> !cmp_stat.busy)
		else $error("compare pipeline busy while taking a box");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> cnt_q == CNT_W'($past(cnt_q) + 1'b1))
		else $error("kept count did not advance on a keep");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !cmp_stat.busy && !issue)
		else $error("decision taken with compares in flight");

endmodule
